@@ rtl/dfrc_pkg.sv @@
// shared types and constants for the depth frame roi / background / clip filter
// used by every module under rtl/ except dfrc_ram
`default_nettype none

package dfrc_pkg;

  // default frame geometry
  localparam int FRAME_WIDTH_DEF  = 640;
  localparam int FRAME_HEIGHT_DEF = 480;

  // field widths
  localparam int DEPTH_W  = 16;
  localparam int ROW_W    = 9;
  localparam int COL_W    = 10;
  localparam int THRESH_W = 7;
  localparam int NEAR_W   = 10;
  localparam int BOUND_W  = 12;
  localparam int SCALE_W  = 9;
  localparam int PROD_W   = DEPTH_W + SCALE_W;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BG_THRESH  = 3'd0,
    REG_NEAR       = 3'd1,
    REG_FAR        = 3'd2,
    REG_ROI_TOP    = 3'd3,
    REG_ROI_BOTTOM = 3'd4,
    REG_ROI_LEFT   = 3'd5,
    REG_ROI_RIGHT  = 3'd6,
    REG_SCALE      = 3'd7
  } reg_idx_t;

  // register reset values
  localparam logic [THRESH_W-1:0] BG_THRESH_RST  = '0;
  localparam logic [NEAR_W-1:0]   NEAR_RST       = '0;
  localparam logic [DEPTH_W-1:0]  FAR_RST        = 16'hFFFF;
  localparam logic [BOUND_W-1:0]  ROI_TOP_RST    = 12'd0;
  localparam logic [BOUND_W-1:0]  ROI_BOTTOM_RST = 12'd2048;
  localparam logic [BOUND_W-1:0]  ROI_LEFT_RST   = 12'd0;
  localparam logic [BOUND_W-1:0]  ROI_RIGHT_RST  = 12'd3072;
  localparam logic [SCALE_W-1:0]  SCALE_RST      = 9'd256;

  // queue between front and back, power of two
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  // stream packing
  localparam int IN_TDATA_W  = 16;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 40;
  localparam int OUT_PAD_W   = OUT_TDATA_W - DEPTH_W - ROW_W - COL_W;

  typedef struct packed {
    logic [BOUND_W-1:0] top;
    logic [BOUND_W-1:0] bottom;
    logic [BOUND_W-1:0] left;
    logic [BOUND_W-1:0] right;
  } roi_cfg_t;

  typedef struct packed {
    logic [THRESH_W-1:0] thresh;
    logic [NEAR_W-1:0]   near_mm;
    logic [DEPTH_W-1:0]  far_mm;
    logic [SCALE_W-1:0]  scale;
  } filt_cfg_t;

  // classified pixel leaving the front
  typedef struct packed {
    logic [DEPTH_W-1:0] depth;
    logic [ROW_W-1:0]   roi_row;
    logic [COL_W-1:0]   roi_col;
    logic               last;
    logic               bg_ok;
  } req_t;

  // queue entry: pixel plus its background sample
  typedef struct packed {
    req_t               req;
    logic [DEPTH_W-1:0] bg;
  } q_ent_t;

endpackage

`default_nettype wire

@@ rtl/dfrc_ram.sv @@
// generic single write port, single read port ram with registered read data
// no dependencies
`default_nettype none

module dfrc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/dfrc_front.sv @@
// front end: accepts pixels, tracks frame position, classifies against the roi,
// writes or reads the background ram; depends on dfrc_pkg and dfrc_ram
`default_nettype none

module dfrc_front #(
  parameter int FRAME_WIDTH  = dfrc_pkg::FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = dfrc_pkg::FRAME_HEIGHT_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  input  wire logic [dfrc_pkg::DEPTH_W-1:0] in_depth,
  input  wire logic                         in_cmd,
  input  wire logic                         in_start,
  input  wire dfrc_pkg::roi_cfg_t           roi_cfg,
  input  wire logic [dfrc_pkg::QCW-1:0]     q_cnt,
  output logic                              q_push,
  output dfrc_pkg::q_ent_t                  q_data
);

  import dfrc_pkg::*;

  localparam int NPIX = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int AW   = (NPIX > 1) ? $clog2(NPIX) : 1;
  localparam int RW   = (FRAME_HEIGHT > 1) ? $clog2(FRAME_HEIGHT) : 1;
  localparam int CW   = (FRAME_WIDTH > 1) ? $clog2(FRAME_WIDTH) : 1;
  localparam logic [BOUND_W-1:0] H_B = BOUND_W'(FRAME_HEIGHT);
  localparam logic [BOUND_W-1:0] W_B = BOUND_W'(FRAME_WIDTH);

  logic [RW-1:0] row_r, row_nxt, row_eff;
  logic [CW-1:0] col_r, col_nxt, col_eff;
  logic [AW-1:0] addr_r, addr_nxt, addr_eff;
  logic          bg_valid_r;
  logic          s1_v_r;
  req_t          s1_req_r;
  req_t          req;
  logic          accept;
  logic          in_roi;
  logic          col_wrap, row_wrap;
  logic [BOUND_W-1:0] top, bottom, left, right, bot_c, right_c;
  logic [BOUND_W-1:0] row_b, col_b, row_off, col_off;
  logic [DEPTH_W-1:0] bg_rdata;

  // room for the item in flight plus everything queued
  assign in_tready = ({1'b0, q_cnt} + (QCW+1)'(s1_v_r)) < (QCW+1)'(QDEPTH);
  assign accept    = in_tvalid & in_tready;

  assign row_eff  = in_start ? '0 : row_r;
  assign col_eff  = in_start ? '0 : col_r;
  assign addr_eff = in_start ? '0 : addr_r;

  assign col_wrap = (col_eff == CW'(FRAME_WIDTH - 1));
  assign row_wrap = (row_eff == RW'(FRAME_HEIGHT - 1));

  always_comb begin
    col_nxt  = col_wrap ? '0 : col_eff + CW'(1);
    row_nxt  = row_eff;
    addr_nxt = addr_eff + AW'(1);
    if (col_wrap) begin
      row_nxt = row_wrap ? '0 : row_eff + RW'(1);
      if (row_wrap) begin
        addr_nxt = '0;
      end
    end
  end

  // region clamp against the frame
  always_comb begin
    top     = (roi_cfg.top > H_B) ? H_B : roi_cfg.top;
    bot_c   = (roi_cfg.bottom > H_B) ? H_B : roi_cfg.bottom;
    bottom  = (bot_c < top) ? top : bot_c;
    left    = (roi_cfg.left > W_B) ? W_B : roi_cfg.left;
    right_c = (roi_cfg.right > W_B) ? W_B : roi_cfg.right;
    right   = (right_c < left) ? left : right_c;
  end

  assign row_b   = BOUND_W'(row_eff);
  assign col_b   = BOUND_W'(col_eff);
  assign row_off = row_b - top;
  assign col_off = col_b - left;
  assign in_roi  = (row_b >= top) && (row_b < bottom) && (col_b >= left) && (col_b < right);

  always_comb begin
    req.depth   = in_depth;
    req.roi_row = row_off[ROW_W-1:0];
    req.roi_col = col_off[COL_W-1:0];
    req.last    = (row_b == bottom - BOUND_W'(1)) && (col_b == right - BOUND_W'(1));
    req.bg_ok   = bg_valid_r;
  end

  dfrc_ram #(
    .WIDTH (DEPTH_W),
    .DEPTH (NPIX),
    .AW    (AW)
  ) u_bg_ram (
    .clk   (clk),
    .we    (accept & in_cmd),
    .waddr (addr_eff),
    .wdata (in_depth),
    .re    (accept & ~in_cmd & in_roi),
    .raddr (addr_eff),
    .rdata (bg_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r      <= '0;
      col_r      <= '0;
      addr_r     <= '0;
      bg_valid_r <= 1'b0;
      s1_v_r     <= 1'b0;
    end else begin
      s1_v_r <= accept & ~in_cmd & in_roi;
      if (accept) begin
        row_r  <= row_nxt;
        col_r  <= col_nxt;
        addr_r <= addr_nxt;
        if (in_cmd) begin
          bg_valid_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_req_r <= req;
    end
  end

  // background sample arrives in the cycle after the read
  assign q_push     = s1_v_r;
  assign q_data.req = s1_req_r;
  assign q_data.bg  = bg_rdata;

endmodule

`default_nettype wire

@@ rtl/dfrc_queue.sv @@
// short fifo decoupling the classifying front from the filtering back end
// depends on dfrc_pkg
`default_nettype none

module dfrc_queue (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     push,
  input  wire dfrc_pkg::q_ent_t         push_data,
  input  wire logic                     pop,
  output logic                          not_empty,
  output dfrc_pkg::q_ent_t              head,
  output logic [dfrc_pkg::QCW-1:0]      cnt
);

  import dfrc_pkg::*;

  q_ent_t          ent_r [QDEPTH];
  logic [QAW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QCW-1:0]  cnt_r, cnt_nxt;
  logic            do_pop;

  assign not_empty = (cnt_r != '0);
  assign head      = ent_r[rd_ptr_r];
  assign cnt       = cnt_r;
  assign do_pop    = pop & not_empty;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + QCW'(1);
    end else if (!push && do_pop) begin
      cnt_nxt = cnt_r - QCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QAW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QAW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

@@ rtl/dfrc_back.sv @@
// back end: background match, near/far clip, q8 gain with saturation, output register
// depends on dfrc_pkg
`default_nettype none

module dfrc_back (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire dfrc_pkg::filt_cfg_t                filt_cfg,
  input  wire logic                               q_valid,
  input  wire dfrc_pkg::q_ent_t                   q_head,
  output logic                                    q_pop,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic [dfrc_pkg::OUT_TDATA_W-1:0]        out_tdata,
  output logic                                    out_tlast
);

  import dfrc_pkg::*;

  logic               b1_v_r, out_v_r;
  logic               b1_en, out_en;
  logic [DEPTH_W-1:0] b1_depth_r;
  logic [ROW_W-1:0]   b1_row_r, out_row_r;
  logic [COL_W-1:0]   b1_col_r, out_col_r;
  logic               b1_last_r, out_last_r;
  logic [DEPTH_W-1:0] out_depth_r;

  logic [DEPTH_W-1:0] d, b, diff, d_bg, d_clip;
  logic               remove;
  logic [PROD_W-1:0]  prod;
  logic [DEPTH_W:0]   scaled;
  logic [DEPTH_W-1:0] sat;

  assign out_en = !out_v_r || out_tready;
  assign b1_en  = !b1_v_r || out_en;
  assign q_pop  = q_valid && b1_en;

  // stage one: background match and range window
  always_comb begin
    d      = q_head.req.depth;
    b      = q_head.bg;
    diff   = (d > b) ? d - b : b - d;
    remove = (filt_cfg.thresh != '0) && q_head.req.bg_ok && (b != '0) &&
             (diff < DEPTH_W'(filt_cfg.thresh));
    d_bg   = remove ? '0 : d;
    d_clip = ((d_bg < DEPTH_W'(filt_cfg.near_mm)) || (d_bg > filt_cfg.far_mm)) ? '0 : d_bg;
  end

  // stage two: gain, truncate, saturate
  assign prod   = PROD_W'(b1_depth_r) * PROD_W'(filt_cfg.scale);
  assign scaled = prod[PROD_W-1:8];
  assign sat    = scaled[DEPTH_W] ? {DEPTH_W{1'b1}} : scaled[DEPTH_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (b1_en) begin
        b1_v_r <= q_valid;
      end
      if (out_en) begin
        out_v_r <= b1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      b1_depth_r <= d_clip;
      b1_row_r   <= q_head.req.roi_row;
      b1_col_r   <= q_head.req.roi_col;
      b1_last_r  <= q_head.req.last;
    end
    if (out_en && b1_v_r) begin
      out_depth_r <= sat;
      out_row_r   <= b1_row_r;
      out_col_r   <= b1_col_r;
      out_last_r  <= b1_last_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, out_col_r, out_row_r, out_depth_r};
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

@@ rtl/depth_frame_roi_background_clip_filter_unit.sv @@
// top level of the depth frame roi / background removal / range clip filter
// holds the configuration registers; depends on dfrc_pkg, dfrc_front, dfrc_queue, dfrc_back
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-------------------------------------------
//  in_     | in        | in_tvalid / in_tready | tdata depth_mm, tuser cmd, frame_start
//  out_    | out       | out_tvalid/out_tready | tdata depth_out_mm, roi_row, roi_col; tlast
//  cfg_    | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// one pixel per clock sustained while the output keeps up; a region pixel passes in turn
// through the background ram read, the queue stage and two filter stages to the output.
// synchronous active-low reset clears control state only; the background ram is not
// cleared and needs no clearing pass. a four-entry queue lets the output stall without
// stalling the input until it fills; store commands and pixels outside the region yield
// no transfer. cfg_ready is always high.
`default_nettype none

module depth_frame_roi_background_clip_filter_unit #(
  parameter int FRAME_WIDTH  = dfrc_pkg::FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = dfrc_pkg::FRAME_HEIGHT_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [dfrc_pkg::IN_TDATA_W-1:0]   in_tdata,   // [15:0] depth_mm
  input  wire logic [dfrc_pkg::IN_TUSER_W-1:0]   in_tuser,   // [0] cmd, [1] frame_start
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // [15:0] depth_out_mm, [24:16] roi_row, [34:25] roi_col, [39:35] zero
  output logic [dfrc_pkg::OUT_TDATA_W-1:0]       out_tdata,
  output logic                                   out_tlast,  // last_of_frame
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [dfrc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [dfrc_pkg::CFG_DATA_W-1:0]   cfg_data
);

  import dfrc_pkg::*;

  logic [THRESH_W-1:0] thresh_r;
  logic [NEAR_W-1:0]   near_r;
  logic [DEPTH_W-1:0]  far_r;
  logic [BOUND_W-1:0]  top_r, bottom_r, left_r, right_r;
  logic [SCALE_W-1:0]  scale_r;

  roi_cfg_t  roi_cfg;
  filt_cfg_t filt_cfg;
  q_ent_t    q_push_data, q_head;
  logic      q_push, q_pop, q_not_empty;
  logic [QCW-1:0] q_cnt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= BG_THRESH_RST;
      near_r   <= NEAR_RST;
      far_r    <= FAR_RST;
      top_r    <= ROI_TOP_RST;
      bottom_r <= ROI_BOTTOM_RST;
      left_r   <= ROI_LEFT_RST;
      right_r  <= ROI_RIGHT_RST;
      scale_r  <= SCALE_RST;
    end else if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_BG_THRESH:  thresh_r <= cfg_data[THRESH_W-1:0];
        REG_NEAR:       near_r   <= cfg_data[NEAR_W-1:0];
        REG_FAR:        far_r    <= cfg_data[DEPTH_W-1:0];
        REG_ROI_TOP:    top_r    <= cfg_data[BOUND_W-1:0];
        REG_ROI_BOTTOM: bottom_r <= cfg_data[BOUND_W-1:0];
        REG_ROI_LEFT:   left_r   <= cfg_data[BOUND_W-1:0];
        REG_ROI_RIGHT:  right_r  <= cfg_data[BOUND_W-1:0];
        REG_SCALE:      scale_r  <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    roi_cfg.top      = top_r;
    roi_cfg.bottom   = bottom_r;
    roi_cfg.left     = left_r;
    roi_cfg.right    = right_r;
    filt_cfg.thresh  = thresh_r;
    filt_cfg.near_mm = near_r;
    filt_cfg.far_mm  = far_r;
    filt_cfg.scale   = scale_r;
  end

  dfrc_front #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_depth  (in_tdata[DEPTH_W-1:0]),
    .in_cmd    (in_tuser[0]),
    .in_start  (in_tuser[1]),
    .roi_cfg   (roi_cfg),
    .q_cnt     (q_cnt),
    .q_push    (q_push),
    .q_data    (q_push_data)
  );

  dfrc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head),
    .cnt       (q_cnt)
  );

  dfrc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .filt_cfg   (filt_cfg),
    .q_valid    (q_not_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

@@ sim/dfrc_filter_checker.sv @@
// checker for the depth frame roi / background / clip filter: watches the pixel, result and
// register channels, predicts every region pixel and compares it with the output transfers
// depends on dfrc_pkg
module dfrc_filter_checker
  import dfrc_pkg::*;
#(
  parameter int FRAME_WIDTH  = FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = FRAME_HEIGHT_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic [IN_TUSER_W-1:0]  in_tuser,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   out_tlast,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     error_count,
  output int                     pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NPIX    = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int ROW_LSB = DEPTH_W;
  localparam int COL_LSB = DEPTH_W + ROW_W;
  localparam int PAD_LSB = COL_LSB + COL_W;

  typedef struct packed {
    logic [DEPTH_W-1:0] depth;
    logic [ROW_W-1:0]   roi_row;
    logic [COL_W-1:0]   roi_col;
    logic               last;
  } pixel_result_t;

  pixel_result_t expected_pixels[$];

  bit [DEPTH_W-1:0]  bg_frame [NPIX];
  bit                bg_loaded;
  int unsigned       row_pos;
  int unsigned       col_pos;

  bit [THRESH_W-1:0] thresh;
  bit [NEAR_W-1:0]   near_lim;
  bit [DEPTH_W-1:0]  far_lim;
  bit [BOUND_W-1:0]  top_reg;
  bit [BOUND_W-1:0]  bottom_reg;
  bit [BOUND_W-1:0]  left_reg;
  bit [BOUND_W-1:0]  right_reg;
  bit [SCALE_W-1:0]  gain;

  function automatic int unsigned clamp_range(int unsigned v, int unsigned lo, int unsigned hi);
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v;
  endfunction

  function automatic void flag_error(string what, logic [63:0] want, logic [63:0] got);
    error_count++;
    if (error_count <= 10) begin
      $display("%0t mismatch on %s: expected %0h, got %0h", $time, what, want, got);
    end
  endfunction

  function automatic void write_setting(reg_idx_t idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_BG_THRESH:  thresh     = data[THRESH_W-1:0];
      REG_NEAR:       near_lim   = data[NEAR_W-1:0];
      REG_FAR:        far_lim    = data[DEPTH_W-1:0];
      REG_ROI_TOP:    top_reg    = data[BOUND_W-1:0];
      REG_ROI_BOTTOM: bottom_reg = data[BOUND_W-1:0];
      REG_ROI_LEFT:   left_reg   = data[BOUND_W-1:0];
      REG_ROI_RIGHT:  right_reg  = data[BOUND_W-1:0];
      REG_SCALE:      gain       = data[SCALE_W-1:0];
      default: ;
    endcase
  endfunction

  // one pixel in raster order: store into the background or filter it
  function automatic void filter_pixel(bit store, bit restart, bit [DEPTH_W-1:0] raw);
    int unsigned   r_top, r_bottom, r_left, r_right;
    int unsigned   idx, d, b, diff, prod;
    pixel_result_t res;
    if (restart) begin
      row_pos = 0;
      col_pos = 0;
    end
    idx = row_pos * FRAME_WIDTH + col_pos;
    if (idx >= NPIX) idx = 0;
    d = 32'(raw);
    r_top    = clamp_range(32'(top_reg), 0, FRAME_HEIGHT);
    r_bottom = clamp_range(32'(bottom_reg), r_top, FRAME_HEIGHT);
    r_left   = clamp_range(32'(left_reg), 0, FRAME_WIDTH);
    r_right  = clamp_range(32'(right_reg), r_left, FRAME_WIDTH);
    if (store) begin
      bg_frame[idx] = raw;
      bg_loaded = 1'b1;
    end else if (r_top < r_bottom && r_left < r_right &&
                 row_pos >= r_top && row_pos < r_bottom &&
                 col_pos >= r_left && col_pos < r_right) begin
      if (thresh != 0 && bg_loaded) begin
        b = 32'(bg_frame[idx]);
        diff = (d > b) ? d - b : b - d;
        // an empty background sample never removes anything
        if (b != 0 && diff < thresh) d = 0;
      end
      if (d < near_lim || d > far_lim) d = 0;
      prod = (d * gain) >> 8;
      if (prod > 65535) prod = 65535;
      res.depth   = prod[DEPTH_W-1:0];
      res.roi_row = ROW_W'(row_pos - r_top);
      res.roi_col = COL_W'(col_pos - r_left);
      res.last    = (row_pos == r_bottom - 1) && (col_pos == r_right - 1);
      expected_pixels.push_back(res);
    end
    col_pos++;
    if (col_pos >= FRAME_WIDTH) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= FRAME_HEIGHT) row_pos = 0;
    end
  endfunction

  function automatic void check_result();
    pixel_result_t want;
    if (expected_pixels.size() == 0) begin
      flag_error("output transfer with nothing pending, tdata", '0, 64'(out_tdata));
      return;
    end
    want = expected_pixels.pop_front();
    if (out_tdata[DEPTH_W-1:0] !== want.depth)
      flag_error("depth_out_mm", 64'(want.depth), 64'(out_tdata[DEPTH_W-1:0]));
    if (out_tdata[ROW_LSB +: ROW_W] !== want.roi_row)
      flag_error("roi_row", 64'(want.roi_row), 64'(out_tdata[ROW_LSB +: ROW_W]));
    if (out_tdata[COL_LSB +: COL_W] !== want.roi_col)
      flag_error("roi_col", 64'(want.roi_col), 64'(out_tdata[COL_LSB +: COL_W]));
    if (out_tdata[OUT_TDATA_W-1:PAD_LSB] !== '0)
      flag_error("tdata padding", '0, 64'(out_tdata[OUT_TDATA_W-1:PAD_LSB]));
    if (out_tlast !== want.last)
      flag_error("last_of_frame", 64'(want.last), 64'(out_tlast));
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      thresh     = BG_THRESH_RST;
      near_lim   = NEAR_RST;
      far_lim    = FAR_RST;
      top_reg    = ROI_TOP_RST;
      bottom_reg = ROI_BOTTOM_RST;
      left_reg   = ROI_LEFT_RST;
      right_reg  = ROI_RIGHT_RST;
      gain       = SCALE_RST;
      bg_loaded  = 1'b0;
      row_pos    = 0;
      col_pos    = 0;
      expected_pixels.delete();
    end else begin
      // a result never leaves in the cycle its pixel is taken, so compare before predicting
      if (out_tvalid && out_tready) check_result();
      if (cfg_valid && cfg_ready) write_setting(reg_idx_t'(cfg_index), cfg_data);
      if (in_tvalid && in_tready) filter_pixel(in_tuser[0], in_tuser[1], in_tdata[DEPTH_W-1:0]);
    end
    pending_count = expected_pixels.size();
  end

endmodule

@@ sim/depth_frame_roi_background_clip_filter_unit_tb.sv @@
// testbench top for the depth frame roi / background / clip filter: drives pixels, register
// writes and output back-pressure, and gives the verdict from the checker's counts
// depends on dfrc_pkg, dfrc_filter_checker and the filter rtl
module depth_frame_roi_background_clip_filter_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dfrc_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct {
    logic [CFG_DATA_W-1:0] thresh;
    logic [CFG_DATA_W-1:0] near_mm;
    logic [CFG_DATA_W-1:0] far_mm;
    logic [CFG_DATA_W-1:0] top;
    logic [CFG_DATA_W-1:0] bottom;
    logic [CFG_DATA_W-1:0] left;
    logic [CFG_DATA_W-1:0] right;
    logic [CFG_DATA_W-1:0] scale;
  } filter_setup_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // [15:0] depth_mm
  logic [IN_TUSER_W-1:0]  in_tuser;   // [0] cmd, [1] frame_start
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // [15:0] depth_out_mm, [24:16] roi_row, [34:25] roi_col
  logic                   out_tlast;  // last_of_frame
  logic                   cfg_valid;
  logic                   cfg_ready;
  reg_idx_t               cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  int            mismatch_count;
  int            pending_count;
  int            quiet_cycles;
  bit            gaps_on;
  filter_setup_t setting;

  depth_frame_roi_background_clip_filter_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  dfrc_filter_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tlast     (out_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .error_count   (mismatch_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // output back-pressure in bursts
  initial begin
    out_tready = 1'b1;
    forever begin
      @(negedge clk);
      if (gaps_on && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk);
        out_tready <= 1'b1;
      end
    end
  end

  // cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("depth_frame_roi_background_clip_filter_unit regression: fail");
      $finish;
    end
  end

  function automatic filter_setup_t make_setting(int thresh, int near_mm, int far_mm, int top,
                                                 int bottom, int left, int right, int scale);
    filter_setup_t s;
    s.thresh  = CFG_DATA_W'(thresh);
    s.near_mm = CFG_DATA_W'(near_mm);
    s.far_mm  = CFG_DATA_W'(far_mm);
    s.top     = CFG_DATA_W'(top);
    s.bottom  = CFG_DATA_W'(bottom);
    s.left    = CFG_DATA_W'(left);
    s.right   = CFG_DATA_W'(right);
    s.scale   = CFG_DATA_W'(scale);
    return s;
  endfunction

  function automatic filter_setup_t random_setting();
    filter_setup_t s;
    case ($urandom_range(0, 5))
      0: s.thresh = CFG_DATA_W'(0);
      1: s.thresh = CFG_DATA_W'(127);
      2: s.thresh = CFG_DATA_W'($urandom_range(0, 65535));  // register keeps the low bits
      default: s.thresh = CFG_DATA_W'($urandom_range(1, 100));
    endcase
    case ($urandom_range(0, 4))
      0: s.near_mm = CFG_DATA_W'(0);
      1: s.near_mm = CFG_DATA_W'(1023);
      default: s.near_mm = CFG_DATA_W'($urandom_range(0, 1000));
    endcase
    case ($urandom_range(0, 5))
      0: s.far_mm = CFG_DATA_W'(65535);
      1: s.far_mm = CFG_DATA_W'(0);
      2: s.far_mm = CFG_DATA_W'($urandom_range(0, 2000));
      default: s.far_mm = CFG_DATA_W'($urandom_range(1000, 65535));
    endcase
    case ($urandom_range(0, 7))
      0: s.top = CFG_DATA_W'(2048);
      1: s.top = CFG_DATA_W'(1);
      2: s.top = CFG_DATA_W'(4095);
      default: s.top = CFG_DATA_W'(0);
    endcase
    case ($urandom_range(0, 6))
      0: s.bottom = CFG_DATA_W'(2048);
      1: s.bottom = CFG_DATA_W'(0);
      2: s.bottom = s.top + CFG_DATA_W'(1);
      3: s.bottom = CFG_DATA_W'(4095);
      default: s.bottom = s.top + CFG_DATA_W'($urandom_range(1, 3));
    endcase
    case ($urandom_range(0, 7))
      0: s.left = CFG_DATA_W'(3072);
      1: s.left = CFG_DATA_W'(639);
      2: s.left = CFG_DATA_W'(4095);
      default: s.left = CFG_DATA_W'($urandom_range(0, 30));
    endcase
    case ($urandom_range(0, 7))
      0: s.right = CFG_DATA_W'(3072);
      1: s.right = CFG_DATA_W'(0);
      2: s.right = s.left + CFG_DATA_W'(1);
      3: s.right = CFG_DATA_W'(4095);
      default: s.right = s.left + CFG_DATA_W'($urandom_range(1, 40));
    endcase
    case ($urandom_range(0, 7))
      0: s.scale = CFG_DATA_W'(0);
      1: s.scale = CFG_DATA_W'(511);
      2: s.scale = CFG_DATA_W'(128);
      3: s.scale = CFG_DATA_W'(384);
      default: s.scale = CFG_DATA_W'($urandom_range(128, 384));
    endcase
    return s;
  endfunction

  // depths clustered around the background level and the window edges
  function automatic logic [DEPTH_W-1:0] pick_depth(int base);
    int v;
    case ($urandom_range(0, 7))
      0: v = $urandom_range(0, 65535);
      1: v = 0;
      2: v = 65535;
      3: v = int'(setting.near_mm[NEAR_W-1:0]) + int'($urandom_range(0, 4)) - 2;
      4: v = int'(setting.far_mm) + int'($urandom_range(0, 4)) - 2;
      default: v = base + int'($urandom_range(0, 240)) - 120;
    endcase
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return v[DEPTH_W-1:0];
  endfunction

  task automatic send_pixel(bit cmd, bit start, logic [DEPTH_W-1:0] depth);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= depth;
    in_tuser  <= {start, cmd};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // wait until every result is out and the pipeline has emptied behind it
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic put_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic load_settings(filter_setup_t s);
    settle();
    setting = s;
    put_reg(REG_BG_THRESH, s.thresh);
    put_reg(REG_NEAR, s.near_mm);
    put_reg(REG_FAR, s.far_mm);
    put_reg(REG_ROI_TOP, s.top);
    put_reg(REG_ROI_BOTTOM, s.bottom);
    put_reg(REG_ROI_LEFT, s.left);
    put_reg(REG_ROI_RIGHT, s.right);
    put_reg(REG_SCALE, s.scale);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int phase_items;
    int run_len;
    int run_kind;
    int bg_base;
    bit run_cmd;
    bit run_start;

    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_BG_THRESH;
    cfg_data  = '0;
    gaps_on   = 1'b0;
    bg_base   = 1000;
    setting   = make_setting(0, 0, 65535, 0, 2048, 0, 3072, 256);
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n   <= 1'b1;
    gaps_on <= 1'b1;
    @(negedge clk);

    // reset settings, whole frame, no background yet
    send_pixel(1'b0, 1'b1, 16'h0000);
    send_pixel(1'b0, 1'b0, 16'hFFFF);
    send_pixel(1'b0, 1'b0, 16'h5555);
    send_pixel(1'b0, 1'b0, 16'hAAAA);

    // window edges and saturation; threshold set but no background stored
    load_settings(make_setting(100, 1000, 60000, 0, 1, 0, 6, 384));
    send_pixel(1'b0, 1'b1, 16'd999);
    send_pixel(1'b0, 1'b0, 16'd1000);
    send_pixel(1'b0, 1'b0, 16'd43690);
    send_pixel(1'b0, 1'b0, 16'd43691);
    send_pixel(1'b0, 1'b0, 16'd60000);
    send_pixel(1'b0, 1'b0, 16'd60001);

    // region clamped to nothing
    load_settings(make_setting(0, 0, 65535, 2048, 2048, 0, 3072, 511));
    send_pixel(1'b0, 1'b1, 16'd5000);
    send_pixel(1'b0, 1'b0, 16'd6000);

    // one run across the end of row 0: background for most of the row,
    // then filtered pixels through the row change
    load_settings(make_setting(0, 0, 65535, 0, 2048, 0, 3072, 256));
    gaps_on <= 1'b0;
    for (int k = 0; k < FRAME_WIDTH_DEF + 20; k++) begin
      send_pixel(k < FRAME_WIDTH_DEF - 40, k == 0, pick_depth(bg_base));
    end
    gaps_on <= 1'b1;

    // background match: equal, empty background, just inside and just outside threshold
    load_settings(make_setting(50, 0, 65535, 0, 1, 0, 6, 256));
    send_pixel(1'b1, 1'b1, 16'd1000);
    send_pixel(1'b1, 1'b0, 16'd0);
    send_pixel(1'b1, 1'b0, 16'd2000);
    send_pixel(1'b1, 1'b0, 16'd3000);
    send_pixel(1'b1, 1'b0, 16'd65535);
    send_pixel(1'b1, 1'b0, 16'd100);
    send_pixel(1'b0, 1'b1, 16'd1000);
    send_pixel(1'b0, 1'b0, 16'd1234);
    send_pixel(1'b0, 1'b0, 16'd2049);
    send_pixel(1'b0, 1'b0, 16'd3050);
    send_pixel(1'b0, 1'b0, 16'd65500);
    send_pixel(1'b0, 1'b0, 16'd50);

    // random settings on short frames that stay within the stored background
    for (int phase = 0; phase < 6; phase++) begin
      load_settings(random_setting());
      bg_base = $urandom_range(300, 3000);
      if (phase >= 4) gaps_on <= 1'b0;
      phase_items = 0;
      while (phase_items < 50) begin
        run_kind = $urandom_range(0, 3);
        run_len  = $urandom_range(1, 48);
        for (int k = 0; k < run_len; k++) begin
          run_start = (k == 0) ? ($urandom_range(0, 15) != 0) : ($urandom_range(0, 63) == 0);
          case (run_kind)
            0: run_cmd = 1'b1;
            1: run_cmd = 1'($urandom_range(0, 1));
            default: run_cmd = 1'b0;
          endcase
          send_pixel(run_cmd, run_start, pick_depth(bg_base));
        end
        phase_items += run_len;
      end
    end

    settle();
    repeat (10) @(negedge clk);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("depth_frame_roi_background_clip_filter_unit regression: pass");
    end else begin
      $display("depth_frame_roi_background_clip_filter_unit regression: fail");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/dfrc_pkg.sv
rtl/dfrc_ram.sv
rtl/dfrc_front.sv
rtl/dfrc_queue.sv
rtl/dfrc_back.sv
rtl/depth_frame_roi_background_clip_filter_unit.sv
sim/dfrc_filter_checker.sv
sim/depth_frame_roi_background_clip_filter_unit_tb.sv
